// ===== rtl/swiqm_pkg.sv =====
// shared types and constants for the sliding window interquartile mean
package swiqm_pkg;

  // width of the window length register
  localparam int CFG_BITS = 6;

  // window length after reset
  localparam logic [CFG_BITS-1:0] RESET_WINDOW = 6'd8;

  // action codes of an input beat
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_CLEAR  = 1'b1;

  // command offered by the front queue to the back sequencer
  typedef struct packed {
    logic valid;
    logic clear;
  } cmd_t;

endpackage

// ===== rtl/swiqm_front.sv =====
// front part: accepts input beats, classifies them and queues them
module swiqm_front #(
  parameter int SAMPLE_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          action,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  output swiqm_pkg::cmd_t               cmd,
  output logic signed [SAMPLE_BITS-1:0] cmd_sample,
  input  logic                          pop
);

  // two-entry queue storage
  logic signed [SAMPLE_BITS-1:0] q_sample [2];
  logic                          q_clear  [2];
  logic                          wr_ptr;
  logic                          rd_ptr;
  logic [1:0]                    used;
  logic                          push;
  logic                          take;

  assign in_stall = (used == 2'd2);
  assign push     = in_valid && !in_stall;
  assign take     = pop && (used != 2'd0);

  // head of the queue
  assign cmd.valid  = (used != 2'd0);
  assign cmd.clear  = q_clear[rd_ptr];
  assign cmd_sample = q_sample[rd_ptr];

  // queue pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      used   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (take) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, take})
        2'b10:   used <= used + 2'd1;
        2'b01:   used <= used - 2'd1;
        default: used <= used;
      endcase
    end
  end

  // queue payload, classified on the way in
  always_ff @(posedge clk) begin
    if (push) begin
      q_sample[wr_ptr] <= sample;
      q_clear[wr_ptr]  <= (action == swiqm_pkg::ACT_CLEAR);
    end
  end

endmodule

// ===== rtl/swiqm_back.sv =====
// back part: sorted window cells, weighted sum walk and floor divider
module swiqm_back #(
  parameter int WINDOW_MAX  = 32,
  parameter int SAMPLE_BITS = 32,
  parameter int CW          = $clog2(WINDOW_MAX + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  swiqm_pkg::cmd_t               cmd,
  input  logic signed [SAMPLE_BITS-1:0] cmd_sample,
  output logic                          pop,
  input  logic [CW-1:0]                 limit,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] iq_mean,
  output logic [CW-1:0]                 fill_count
);

  localparam int AW   = $clog2(WINDOW_MAX);
  localparam int NUMW = SAMPLE_BITS + $clog2(WINDOW_MAX) + 3;
  localparam int DENW = CW + 1;
  localparam int DCW  = $clog2(NUMW + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_DROP, S_INSERT, S_SUM, S_DIV, S_FIX, S_OUT
  } state_t;

  state_t                        state;
  logic signed [SAMPLE_BITS-1:0] data [WINDOW_MAX];
  logic [AW-1:0]                 age  [WINDOW_MAX];
  logic [CW-1:0]                 held;
  logic signed [SAMPLE_BITS-1:0] v;
  logic [CW-1:0]                 idx;
  logic signed [NUMW-1:0]        acc;
  logic [NUMW-1:0]               quot;
  logic [DENW-1:0]               rem;
  logic [DENW-1:0]               den;
  logic                          neg;
  logic [DCW-1:0]                dcnt;

  // per-cell compare and shift sources
  logic [WINDOW_MAX-1:0]         gt;
  logic [WINDOW_MAX-1:0]         gt_prev;
  logic [WINDOW_MAX-1:0]         oldest;
  logic [WINDOW_MAX-1:0]         after_old;
  logic signed [SAMPLE_BITS-1:0] data_up [WINDOW_MAX];
  logic signed [SAMPLE_BITS-1:0] data_dn [WINDOW_MAX];
  logic [AW-1:0]                 age_up  [WINDOW_MAX];
  logic [AW-1:0]                 age_dn  [WINDOW_MAX];
  logic [CW-1:0]                 held_m1;
  logic                          or_run;

  assign held_m1 = held - CW'(1);

  always_comb begin
    or_run = 1'b0;
    for (int k = 0; k < WINDOW_MAX; k++) begin
      gt[k]     = (CW'(k) < held) && (data[k] > v);
      oldest[k] = (CW'(k) < held) && (age[k] == AW'(held_m1));
      or_run    = or_run | oldest[k];
      after_old[k] = or_run;
    end
    gt_prev    = {gt[WINDOW_MAX-2:0], 1'b0};
    data_up[0] = v;
    age_up[0]  = '0;
    for (int k = 1; k < WINDOW_MAX; k++) begin
      data_up[k] = data[k-1];
      age_up[k]  = age[k-1] + AW'(1);
    end
    for (int k = 0; k < WINDOW_MAX - 1; k++) begin
      data_dn[k] = data[k+1];
      age_dn[k]  = age[k+1];
    end
    data_dn[WINDOW_MAX-1] = data[WINDOW_MAX-1];
    age_dn[WINDOW_MAX-1]  = age[WINDOW_MAX-1];
  end

  // weighting of the entry under the walk pointer
  logic [CW-1:0]                 quarter;
  logic [1:0]                    rmd;
  logic                          small_n;
  logic signed [SAMPLE_BITS-1:0] x;
  logic signed [NUMW-1:0]        xe;
  logic signed [NUMW-1:0]        term;
  logic signed [NUMW-1:0]        acc_next;
  logic [DENW-1:0]               den_next;

  assign quarter = held >> 2;
  assign rmd     = held[1:0];
  assign small_n = (32'(held) <= 4);
  assign x       = data[idx[AW-1:0]];
  assign xe      = NUMW'(x);

  always_comb begin
    term = '0;
    if (small_n) begin
      term = xe;
      den_next = DENW'(held);
    end else if (rmd == 2'd0) begin
      if (idx >= quarter && idx < held - quarter) begin
        term = xe;
      end
      den_next = DENW'(held >> 1);
    end else begin
      if (idx == quarter || idx == held_m1 - quarter) begin
        case (rmd)
          2'd1:    term = xe + (xe <<< 1);
          2'd2:    term = xe <<< 1;
          default: term = xe;
        endcase
      end else if (idx > quarter && idx < held_m1 - quarter) begin
        term = xe <<< 2;
      end
      den_next = {held, 1'b0};
    end
    acc_next = acc + term;
  end

  // one restoring divide step
  logic [DENW:0] trial;
  logic          fits;
  assign trial = {rem, quot[NUMW-1]};
  assign fits  = (trial >= {1'b0, den});

  // floor correction of the magnitude quotient
  logic [NUMW-1:0] q_pos;
  logic [NUMW-1:0] q_res;
  assign q_pos = quot + NUMW'(rem != '0);
  assign q_res = neg ? (~q_pos + NUMW'(1)) : quot;

  assign pop        = (state == S_IDLE) && cmd.valid;
  assign fill_count = held;

  // sequencer, window cells and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      held      <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            if (cmd.clear) begin
              held <= '0;
            end else begin
              v     <= cmd_sample;
              state <= S_DROP;
            end
          end
        end
        S_DROP: begin
          // one eviction of the oldest entry per cycle
          if (held >= limit && held != '0) begin
            for (int k = 0; k < WINDOW_MAX; k++) begin
              if (after_old[k]) begin
                data[k] <= data_dn[k];
                age[k]  <= age_dn[k];
              end
            end
            held <= held_m1;
          end else begin
            state <= S_INSERT;
          end
        end
        S_INSERT: begin
          // every cell ages, cells above the slot move up one
          for (int k = 0; k < WINDOW_MAX; k++) begin
            if (gt_prev[k]) begin
              data[k] <= data_up[k];
              age[k]  <= age_up[k];
            end else if (gt[k] || CW'(k) >= held) begin
              data[k] <= v;
              age[k]  <= '0;
            end else begin
              age[k]  <= age[k] + AW'(1);
            end
          end
          held  <= held + CW'(1);
          idx   <= '0;
          acc   <= '0;
          state <= S_SUM;
        end
        S_SUM: begin
          acc <= acc_next;
          idx <= idx + CW'(1);
          if (idx == held_m1) begin
            neg   <= acc_next[NUMW-1];
            quot  <= acc_next[NUMW-1] ? (~acc_next + NUMW'(1)) : acc_next;
            rem   <= '0;
            den   <= den_next;
            dcnt  <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          rem  <= fits ? DENW'(trial - {1'b0, den}) : DENW'(trial);
          quot <= {quot[NUMW-2:0], fits};
          dcnt <= dcnt + DCW'(1);
          if (dcnt == DCW'(NUMW - 1)) begin
            state <= S_FIX;
          end
        end
        S_FIX: begin
          iq_mean   <= q_res[SAMPLE_BITS-1:0];
          out_valid <= 1'b1;
          state     <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // window never overfills
  assert property (@(posedge clk) disable iff (rst) 32'(held) <= WINDOW_MAX)
    else $error("window count above capacity");

  // a result always reports a nonempty window
  assert property (@(posedge clk) disable iff (rst) out_valid |-> held != '0)
    else $error("result with empty window");

  // divisor is never zero while dividing
  assert property (@(posedge clk) disable iff (rst) state == S_DIV |-> den != '0)
    else $error("zero divisor");

  // result stays until taken
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(iq_mean))
    else $error("result dropped while stalled");

endmodule

// ===== rtl/sliding_window_interquartile_mean.sv =====
// top level: window length register, front queue and back sequencer
// the back part takes a beat from the queue, evicts oldest entries until the window is below its length
//   (d = evictions, 0 .. WINDOW_MAX), inserts, walks the n entries held after the insert and divides
//   in NUMW = SAMPLE_BITS + log2(WINDOW_MAX) + 3 divide steps, then holds the result until it is taken
// it takes no new insert beat before then; a clear beat empties the window and gives no result;
//   the two-entry queue takes beats while a result waits
// reset: window emptied, window length 8, queue emptied and result valid cleared
module sliding_window_interquartile_mean #(
  parameter int WINDOW_MAX  = 32,
  parameter int SAMPLE_BITS = 32
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_write,
  input  logic [swiqm_pkg::CFG_BITS-1:0]         window_length,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   action,
  input  logic signed [SAMPLE_BITS-1:0]          sample,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [SAMPLE_BITS-1:0]          iq_mean,
  output logic [$clog2(WINDOW_MAX+1)-1:0]        fill_count
);

  localparam int CW = $clog2(WINDOW_MAX + 1);

  logic [swiqm_pkg::CFG_BITS-1:0] wlen;
  logic [CW-1:0]                  limit;
  swiqm_pkg::cmd_t                cmd;
  logic signed [SAMPLE_BITS-1:0]  cmd_sample;
  logic                           pop;

  // window length register
  always_ff @(posedge clk) begin
    if (rst) begin
      wlen <= swiqm_pkg::RESET_WINDOW;
    end else if (cfg_write) begin
      wlen <= window_length;
    end
  end

  // zero means one, above capacity saturates
  always_comb begin
    if (wlen == '0) begin
      limit = CW'(1);
    end else if (32'(wlen) > WINDOW_MAX) begin
      limit = CW'(WINDOW_MAX);
    end else begin
      limit = CW'(wlen);
    end
  end

  swiqm_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .action     (action),
    .sample     (sample),
    .cmd        (cmd),
    .cmd_sample (cmd_sample),
    .pop        (pop)
  );

  swiqm_back #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS),
    .CW          (CW)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .cmd_sample (cmd_sample),
    .pop        (pop),
    .limit      (limit),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .iq_mean    (iq_mean),
    .fill_count (fill_count)
  );

endmodule

// ===== dv/testbench.sv =====
// self-checking testbench for the sliding window interquartile mean
module testbench;

  localparam int WMAX = 32;
  localparam int LIMIT_CYCLES = 2000000;
  localparam int DRAIN_CYCLES = 200;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [swiqm_pkg::CFG_BITS-1:0] window_length = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic action = swiqm_pkg::ACT_INSERT;
  logic signed [31:0] sample = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] iq_mean;
  logic [5:0] fill_count;

  typedef struct {
    logic signed [31:0] mean;
    logic [5:0] count;
  } window_result_t;

  // predictor state
  longint win_val[WMAX];
  int win_age[WMAX];
  int win_fill;
  logic [swiqm_pkg::CFG_BITS-1:0] win_len;

  window_result_t expected_means[$];
  int errors = 0;
  int cycle = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_off = 0;
  int inserts_sent = 0;
  int clears_sent = 0;
  int means_checked = 0;

  sliding_window_interquartile_mean dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .window_length(window_length),
    .in_valid(in_valid), .in_stall(in_stall), .action(action), .sample(sample),
    .out_valid(out_valid), .out_stall(out_stall), .iq_mean(iq_mean),
    .fill_count(fill_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // timeout guard
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // remove one entry at a position, shifting the rest down
  function automatic void drop_at(int pos);
    for (int k = pos; k + 1 < win_fill; k++) begin
      win_val[k] = win_val[k + 1];
      win_age[k] = win_age[k + 1];
    end
    win_fill--;
  endfunction

  function automatic longint floor_quot(longint num, longint den);
    longint q;
    q = num / den;
    if ((num % den) != 0 && num < 0) q--;
    return q;
  endfunction

  // interquartile mean of the held sorted entries
  function automatic longint window_iq_mean();
    longint num;
    longint den;
    longint full;
    int n, f, r;
    n = win_fill;
    num = 0;
    full = 0;
    if (n <= 4) begin
      for (int k = 0; k < n; k++) num += win_val[k];
      den = n;
    end else if (n % 4 == 0) begin
      for (int k = n / 4; k < 3 * (n / 4); k++) num += win_val[k];
      den = n / 2;
    end else begin
      f = n / 4;
      r = n % 4;
      for (int k = f + 1; k + 1 + f < n; k++) full += win_val[k];
      num = (4 - r) * (win_val[f] + win_val[n - 1 - f]) + 4 * full;
      den = 2 * n;
    end
    return floor_quot(num, den);
  endfunction

  // apply one beat to the predicted window
  function automatic void predict_beat(logic act, logic signed [31:0] smp);
    int lim, pos, found;
    window_result_t res;
    if (act == swiqm_pkg::ACT_CLEAR) begin
      win_fill = 0;
      return;
    end
    lim = (win_len == 0) ? 1 : ((win_len > WMAX) ? WMAX : int'(win_len));
    // evict oldest until there is room
    while (win_fill >= lim && win_fill > 0) begin
      found = win_fill - 1;
      for (int k = win_fill - 1; k >= 0; k--)
        if (win_age[k] == win_fill - 1) found = k;
      drop_at(found);
    end
    for (int k = 0; k < win_fill; k++) win_age[k]++;
    pos = 0;
    while (pos < win_fill && win_val[pos] <= longint'(smp)) pos++;
    for (int k = win_fill; k > pos; k--) begin
      win_val[k] = win_val[k - 1];
      win_age[k] = win_age[k - 1];
    end
    win_val[pos] = smp;
    win_age[pos] = 0;
    win_fill++;
    res.mean = 32'(window_iq_mean());
    res.count = 6'(win_fill);
    expected_means.push_back(res);
  endfunction

  // send one beat, waiting for acceptance
  task automatic send_beat(logic act, logic signed [31:0] smp);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    sample <= smp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_beat(act, smp);
    if (act == swiqm_pkg::ACT_CLEAR) clears_sent++; else inserts_sent++;
    @(negedge clk);
  endtask

  // receiver stall generation
  always @(negedge clk) begin
    if (rst) out_stall <= 1'b0;
    else if (hold_off > 0) begin
      out_stall <= 1'b1;
      hold_off <= hold_off - 1;
    end else out_stall <= (recv_idle_pct > 0) && ($urandom_range(99) < recv_idle_pct);
  end

  // result checker
  always @(posedge clk) begin
    window_result_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      if (expected_means.size() == 0) begin
        $error("unexpected result iq_mean=%0d fill_count=%0d", iq_mean, fill_count);
        errors++;
      end else begin
        exp_r = expected_means.pop_front();
        means_checked++;
        if (iq_mean !== exp_r.mean) begin
          $error("iq_mean expected %0d actual %0d", exp_r.mean, iq_mean);
          errors++;
        end
        if (fill_count !== exp_r.count) begin
          $error("fill_count expected %0d actual %0d", exp_r.count, fill_count);
          errors++;
        end
      end
    end
  end

  // stop offering, then wait for all results plus settle time
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_means.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_window(logic [swiqm_pkg::CFG_BITS-1:0] len);
    drain();
    cfg_write <= 1'b1;
    window_length <= len;
    @(negedge clk);
    cfg_write <= 1'b0;
    win_len = len;
  endtask

  function automatic logic signed [31:0] rand_sample();
    case ($urandom_range(5))
      0: return 32'sh7FFFFFFF;
      1: return 32'sh80000000;
      2: return $urandom_range(7) - 3;
      3: return $signed($urandom_range(65536 * 4)) - 131072;
      default: return $urandom;
    endcase
  endfunction

  // extremes, duplicates, plain mean sizes and clear
  task automatic test_directed();
    send_beat(swiqm_pkg::ACT_INSERT, 32'sh7FFFFFFF);
    send_beat(swiqm_pkg::ACT_INSERT, 32'sh7FFFFFFF);
    send_beat(swiqm_pkg::ACT_INSERT, 32'sh80000000);
    send_beat(swiqm_pkg::ACT_INSERT, 32'sh80000000);
    send_beat(swiqm_pkg::ACT_INSERT, 32'sh00010000);
    send_beat(swiqm_pkg::ACT_INSERT, 32'sh00010000);
    send_beat(swiqm_pkg::ACT_INSERT, -32'sd1);
    send_beat(swiqm_pkg::ACT_INSERT, 32'sd0);
    send_beat(swiqm_pkg::ACT_INSERT, 32'sd5);
    send_beat(swiqm_pkg::ACT_CLEAR, 32'sh5A5A5A5A);
    send_beat(swiqm_pkg::ACT_INSERT, -32'sd7);
    send_beat(swiqm_pkg::ACT_INSERT, 32'sd2);
    send_beat(swiqm_pkg::ACT_CLEAR, 32'sd0);
  endtask

  // random inserts with occasional clears at the current window length
  task automatic test_random(int count);
    for (int i = 0; i < count; i++)
      send_beat(($urandom_range(39) == 0) ? swiqm_pkg::ACT_CLEAR : swiqm_pkg::ACT_INSERT,
                rand_sample());
  endtask

  // window lengths including zero, one, max, above max and shrinking
  task automatic test_window_lengths();
    logic [swiqm_pkg::CFG_BITS-1:0] lens[8] =
      '{6'd0, 6'd1, 6'd32, 6'd63, 6'd5, 6'd13, 6'd2, 6'd33};
    foreach (lens[i]) begin
      set_window(lens[i]);
      test_random(40);
    end
  endtask

  // long receiver hold-off so the input queue backs up
  task automatic test_backpressure();
    hold_off <= 400;
    test_random(8);
  endtask

  initial begin
    win_fill = 0;
    win_len = swiqm_pkg::RESET_WINDOW;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_window_lengths();
    set_window(6'd17);
    test_backpressure();
    send_idle_pct = 6;
    recv_idle_pct = 50;
    test_random(250);
    set_window(6'd8);
    send_idle_pct = 50;
    recv_idle_pct = 6;
    test_random(250);
    set_window(6'd31);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(150);
    drain();
    $display("covered %0d inserts and %0d clears, %0d means checked over several window lengths",
             inserts_sent, clears_sent, means_checked);
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule

// ===== sliding_window_interquartile_mean.f =====
rtl/swiqm_pkg.sv
rtl/swiqm_front.sv
rtl/swiqm_back.sv
rtl/sliding_window_interquartile_mean.sv
dv/testbench.sv
